FILE: rtl/core/keyed_timeout_table_defines.svh
// keyed_timeout_table assertion macros
`ifndef KEYED_TIMEOUT_TABLE_DEFINES_SVH
`define KEYED_TIMEOUT_TABLE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define KTT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define KTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define KTT_ASSERT(label, prop, msg)
`define KTT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/core/ktt_pkg.sv
// ----------------------------------------------------------------------------
// ktt_pkg
// Types, codes and helpers shared by the keyed timeout table.
// ----------------------------------------------------------------------------
package ktt_pkg;

  localparam int DEF_TABLE_ENTRIES     = 16;
  localparam int DEF_KEY_MAX_BYTES     = 8;
  localparam int DEF_PAYLOAD_MAX_BYTES = 8;

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_ADD    = 3'd1;
  localparam logic [2:0] CMD_EXIST  = 3'd2;
  localparam logic [2:0] CMD_GET    = 3'd3;
  localparam logic [2:0] CMD_DELETE = 3'd4;
  localparam logic [2:0] CMD_CHECK  = 3'd5;
  localparam logic [2:0] CMD_NEXT   = 3'd6;

  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_KEY       = 3'd1;
  localparam logic [2:0] STS_TOO_SMALL = 3'd2;
  localparam logic [2:0] STS_FULL      = 3'd3;
  localparam logic [2:0] STS_NONE      = 3'd4;

  typedef struct packed {
    logic [2:0]         command;
    logic [63:0]        key_bytes;
    logic [3:0]         key_length;
    logic [63:0]        payload;
    logic [3:0]         payload_length;
    logic [31:0]        timeout_seconds;
    logic [3:0]         max_payload_length;
    logic [3:0]         max_key_length;
    logic signed [31:0] timeout_limit;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [63:0]        out_key;
    logic [3:0]         out_key_length;
    logic [63:0]        out_payload;
    logic [3:0]         out_payload_length;
    logic signed [31:0] next_timeout;
  } result_t;

  typedef struct packed {
    logic [63:0] key;
    logic [3:0]  key_length;
    logic [63:0] payload;
    logic [3:0]  payload_length;
    logic [32:0] expiry;
  } entry_t;

  typedef struct packed {
    logic latch;
    logic now_inc;
    logic idx_inc;
    logic rd_next;
    logic wr_app;
    logic wr_shift;
    logic cnt_inc;
    logic cnt_dec;
    logic eval;
    logic miss;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       scan_end;
    logic       last;
    logic       hit;
    logic       remove;
    logic       full;
  } dp_status_t;

  function automatic logic [63:0] byte_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < len) m[8*b +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

FILE: rtl/core/ktt_ram.sv
// ----------------------------------------------------------------------------
// ktt_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ktt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

FILE: rtl/core/ktt_datapath.sv
// ----------------------------------------------------------------------------
// ktt_datapath
// Request latch, clock, entry count, scan index, entry RAM and result regs.
// ----------------------------------------------------------------------------
module ktt_datapath #(
  parameter int TABLE_ENTRIES     = 16,
  parameter int KEY_MAX_BYTES     = 8,
  parameter int PAYLOAD_MAX_BYTES = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  ktt_pkg::in_item_t   item,
  input  ktt_pkg::ctrl_cmd_t  cmd,
  output ktt_pkg::dp_status_t sts,
  output ktt_pkg::result_t    result
);
  import ktt_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);
  localparam logic [3:0] KMAX = 4'(KEY_MAX_BYTES);
  localparam logic [3:0] PMAX = 4'(PAYLOAD_MAX_BYTES);
  localparam logic signed [33:0] REM_MAX = 34'sh7FFFFFFF;

  logic [31:0]        now_seconds;
  logic [CNT_W-1:0]   entry_count;
  logic [CNT_W-1:0]   idx;
  in_item_t           req;
  in_item_t           req_next;
  result_t            res;
  logic signed [33:0] lim;

  logic [3:0]       kl, pl;
  logic [CNT_W-1:0] idx_p1;
  entry_t           rdata, new_entry, wr_data;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic             wr_en;
  logic             match, expired, get_small, chk_small, hit;
  logic signed [33:0] rem, rem_clamp;

  assign kl = (item.key_length > KMAX) ? KMAX : item.key_length;
  assign pl = (item.payload_length > PMAX) ? PMAX : item.payload_length;
  assign idx_p1 = idx + 1'b1;

  // clamp lengths and clear unused bytes before the request is held
  always_comb begin
    req_next                = item;
    req_next.key_length     = kl;
    req_next.key_bytes      = item.key_bytes & byte_mask(kl);
    req_next.payload_length = pl;
    req_next.payload        = item.payload & byte_mask(pl);
  end

  always_comb begin
    new_entry.key            = req.key_bytes;
    new_entry.key_length     = req.key_length;
    new_entry.payload        = req.payload;
    new_entry.payload_length = req.payload_length;
    new_entry.expiry         = {1'b0, now_seconds} + {1'b0, req.timeout_seconds};
  end

  assign wr_en   = cmd.wr_app | cmd.wr_shift;
  assign wr_addr = cmd.wr_app ? entry_count[IDX_W-1:0] : idx[IDX_W-1:0];
  assign wr_data = cmd.wr_app ? new_entry : rdata;
  assign rd_addr = cmd.rd_next ? idx_p1[IDX_W-1:0] : idx[IDX_W-1:0];

  ktt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rdata)
  );

  assign match     = (rdata.key_length == req.key_length) && (rdata.key == req.key_bytes);
  assign expired   = rdata.expiry <= {1'b0, now_seconds};
  assign get_small = rdata.payload_length > req.max_payload_length;
  assign chk_small = ((req.max_key_length != 4'd0) &&
                      (rdata.key_length > req.max_key_length)) ||
                     ((req.max_payload_length != 4'd0) &&
                      (rdata.payload_length > req.max_payload_length));
  assign rem = $signed({1'b0, rdata.expiry}) - $signed({2'b00, now_seconds});
  assign rem_clamp = (rem < 0) ? 34'sd0 : ((rem > REM_MAX) ? REM_MAX : rem);

  always_comb begin
    case (req.command)
      CMD_ADD, CMD_EXIST, CMD_GET, CMD_DELETE: hit = match;
      CMD_CHECK: hit = expired;
      default: hit = 1'b0;
    endcase
  end

  assign sts.cmd      = req.command;
  assign sts.scan_end = (idx == entry_count);
  assign sts.last     = (idx_p1 >= entry_count);
  assign sts.hit      = hit;
  assign sts.remove   = hit && ((req.command == CMD_DELETE) ||
                                ((req.command == CMD_CHECK) && !chk_small));
  assign sts.full     = (entry_count >= FULL_CNT);

  assign result = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      now_seconds <= '0;
      entry_count <= '0;
      idx         <= '0;
    end else begin
      if (cmd.now_inc && (now_seconds != 32'hFFFF_FFFF)) now_seconds <= now_seconds + 32'd1;
      if (cmd.cnt_inc) entry_count <= entry_count + 1'b1;
      if (cmd.cnt_dec) entry_count <= entry_count - 1'b1;
      if (cmd.latch) idx <= '0;
      else if (cmd.idx_inc) idx <= idx_p1;
    end
  end

  // request and result registers carry payload only
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req <= req_next;
      res <= '0;
      lim <= 34'(item.timeout_limit);
    end
    if (cmd.eval) begin
      if (req.command == CMD_NEXT) begin
        if ((lim < 0) || (rem < lim)) lim <= rem_clamp;
      end else if (hit) begin
        case (req.command)
          CMD_GET: begin
            if (get_small) res.status <= STS_TOO_SMALL;
            else begin
              res.out_payload        <= rdata.payload;
              res.out_payload_length <= rdata.payload_length;
            end
          end
          CMD_ADD: res.status <= STS_KEY;
          CMD_CHECK: begin
            if (chk_small) res.status <= STS_TOO_SMALL;
            else begin
              if (req.max_payload_length != 4'd0) res.out_payload <= rdata.payload;
              res.out_payload_length <= rdata.payload_length;
              if (req.max_key_length != 4'd0) res.out_key <= rdata.key;
              res.out_key_length <= rdata.key_length;
            end
          end
          default: ;
        endcase
      end
    end
    if (cmd.miss) begin
      case (req.command)
        CMD_ADD:                        res.status <= STS_FULL;
        CMD_EXIST, CMD_GET, CMD_DELETE: res.status <= STS_KEY;
        CMD_CHECK:                      res.status <= STS_NONE;
        CMD_NEXT:                       res.next_timeout <= lim[31:0];
        default: ;
      endcase
    end
  end
endmodule

FILE: rtl/core/ktt_ctrl.sv
// ----------------------------------------------------------------------------
// ktt_ctrl
// Command sequencer: scan, append, compact and result strobe.
// ----------------------------------------------------------------------------
`include "keyed_timeout_table_defines.svh"
module ktt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [2:0]          command,
  input  ktt_pkg::dp_status_t sts,
  output ktt_pkg::ctrl_cmd_t  cmd,
  output logic                busy,
  output logic                result_valid
);
  import ktt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EV   = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_CRD  = 3'd4;
  localparam logic [2:0] S_CWR  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          if (command == CMD_TICK) begin
            cmd.now_inc = 1'b1;
            state_next  = S_DONE;
          end else if (command == CMD_ADD || command == CMD_EXIST ||
                       command == CMD_GET || command == CMD_DELETE ||
                       command == CMD_CHECK || command == CMD_NEXT) begin
            state_next = S_RD;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_RD: begin
        if (sts.scan_end) begin
          if (sts.cmd == CMD_ADD && !sts.full) state_next = S_WR;
          else begin
            cmd.miss   = 1'b1;
            state_next = S_DONE;
          end
        end else begin
          state_next = S_EV;
        end
      end
      S_EV: begin
        cmd.eval = 1'b1;
        if (sts.remove) state_next = S_CRD;
        else if (sts.hit) state_next = S_DONE;
        else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_RD;
        end
      end
      S_CRD: begin
        if (sts.last) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.rd_next = 1'b1;
          state_next  = S_CWR;
        end
      end
      S_CWR: begin
        // move the entry above down into the gap
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_next   = S_CRD;
      end
      S_WR: begin
        cmd.wr_app  = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign busy         = (state != S_IDLE);
  assign result_valid = (state == S_DONE);

  `KTT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not start work")
  `KTT_ASSERT_NEXT(a_done_idle, result_valid, !busy, "block stayed busy after result")
  `KTT_ASSERT(a_append_room, (state == S_WR) |-> !sts.full, "append into a full table")
endmodule

FILE: rtl/core/keyed_timeout_table.sv
// ----------------------------------------------------------------------------
// keyed_timeout_table
// Insertion-ordered timer table with key lookup, expiry check and compaction.
//
//   channel  direction  handshake                 payload
//   item     in         start && !busy            ktt_pkg::in_item_t
//   result   out        result_valid, one cycle   ktt_pkg::result_t
//
// Tick and unknown commands go straight to the result state. A lookup reads
// and then evaluates each entry in order until it hits; a miss ends at the
// scan end, where an append adds a write state. A removal then moves each later
// entry down one place. Entries pass through the single entry RAM read port.
// Synchronous reset empties the table and clears the clock.
// busy stays high from acceptance until the result cycle ends; results
// cannot be held off.
// ----------------------------------------------------------------------------
module keyed_timeout_table #(
  parameter int TABLE_ENTRIES     = ktt_pkg::DEF_TABLE_ENTRIES,
  parameter int KEY_MAX_BYTES     = ktt_pkg::DEF_KEY_MAX_BYTES,
  parameter int PAYLOAD_MAX_BYTES = ktt_pkg::DEF_PAYLOAD_MAX_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ktt_pkg::in_item_t item,
  output logic              busy,
  output logic              result_valid,
  output ktt_pkg::result_t  result
);
  import ktt_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  ktt_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .command     (item.command),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy),
    .result_valid(result_valid)
  );

  ktt_datapath #(
    .TABLE_ENTRIES    (TABLE_ENTRIES),
    .KEY_MAX_BYTES    (KEY_MAX_BYTES),
    .PAYLOAD_MAX_BYTES(PAYLOAD_MAX_BYTES)
  ) u_dp (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .cmd   (cmd),
    .sts   (sts),
    .result(result)
  );
endmodule
